// ----- design/tls_pkg.sv -----
// shared types and constants for the traffic light sequencer
`default_nettype none

package tls_pkg;

  // configuration register widths and indexes
  localparam int CFG_W     = 16;
  localparam int CFG_IDX_W = 3;

  localparam logic [CFG_IDX_W-1:0] REG_RED_TIME        = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RED_YELLOW_TIME = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GREEN_TIME      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_GREEN_MIN_TIME  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_YELLOW_TIME     = 3'd4;

  // reset values of the phase durations, milliseconds
  localparam logic [CFG_W-1:0] RST_RED_TIME        = 16'd5000;
  localparam logic [CFG_W-1:0] RST_RED_YELLOW_TIME = 16'd1000;
  localparam logic [CFG_W-1:0] RST_GREEN_TIME      = 16'd7000;
  localparam logic [CFG_W-1:0] RST_GREEN_MIN_TIME  = 16'd4000;
  localparam logic [CFG_W-1:0] RST_YELLOW_TIME     = 16'd2000;

  // stream payload widths
  localparam int ELAPSED_W = 16;
  localparam int IN_DATA_W = 24;
  localparam int OUT_DATA_W = 8;

  typedef enum logic [1:0] {
    PH_RED        = 2'd0,
    PH_RED_YELLOW = 2'd1,
    PH_GREEN      = 2'd2,
    PH_YELLOW     = 2'd3
  } phase_t;

endpackage

`default_nettype wire

// ----- design/traffic_light_sequencer_top.sv -----
// traffic light sequencer top level: phase state machine behind a stream interface
// the result of an input beat is registered and shows on the master side in the cycle after the beat is taken
// throughput: one input beat per cycle; the only stall is a held result beat
// each beat is one add with saturation, a few compares and a phase update
// reset (rst, synchronous, active high): phase red, time zero, no walk request,
// durations back to their defaults, output buffer empty
`default_nettype none

module traffic_light_sequencer_top
  import tls_pkg::*;
#(
  parameter int TIME_WIDTH = 16
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  // input stream
  input  wire logic                  s_tvalid,
  output logic                       s_tready,
  input  wire logic [IN_DATA_W-1:0]  s_tdata,   // elapsed[15:0], walk_button[16], zero pad
  // result stream
  output logic                       m_tvalid,
  input  wire logic                  m_tready,
  output logic [OUT_DATA_W-1:0]      m_tdata,   // phase[1:0], red_lamp[2], yellow_lamp[3],
                                                // green_lamp[4], walk_waiting[5], zero pad
  // configuration writes
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_W-1:0]      cfg_data
);

  // compare width covers both the accumulator and the 16 bit durations
  localparam int CW = (TIME_WIDTH > CFG_W) ? TIME_WIDTH : CFG_W;
  localparam logic [CW:0] TIME_MAX = (CW+1)'({TIME_WIDTH{1'b1}});

  // duration registers
  logic [CFG_W-1:0] red_time;
  logic [CFG_W-1:0] red_yellow_time;
  logic [CFG_W-1:0] green_time;
  logic [CFG_W-1:0] green_min_time;
  logic [CFG_W-1:0] yellow_time;

  // sequencer state
  phase_t                phase;
  phase_t                phase_next;
  logic [TIME_WIDTH-1:0] phase_time;
  logic [TIME_WIDTH-1:0] phase_time_next;
  logic                  walk_pending;
  logic                  walk_pending_next;

  // input beat fields
  logic [ELAPSED_W-1:0] elapsed;
  logic                 walk_button;

  logic                 s_accept;
  logic [CW:0]          sum;
  logic [TIME_WIDTH-1:0] sat_time;
  logic [CW-1:0]        cmp_time;
  logic                 pend_seen;

  // result fields, decoded from the next phase
  logic red_lamp;
  logic yellow_lamp;
  logic green_lamp;

  assign elapsed     = s_tdata[ELAPSED_W-1:0];
  assign walk_button = s_tdata[ELAPSED_W];

  // the result register parts the two sides: take a beat unless a result is held
  assign s_tready  = !m_tvalid || m_tready;
  assign s_accept  = s_tvalid && s_tready;
  assign cfg_ready = 1'b1;

  // configuration writes, unknown indexes fall through
  always_ff @(posedge clk) begin
    if (rst) begin
      red_time        <= RST_RED_TIME;
      red_yellow_time <= RST_RED_YELLOW_TIME;
      green_time      <= RST_GREEN_TIME;
      green_min_time  <= RST_GREEN_MIN_TIME;
      yellow_time     <= RST_YELLOW_TIME;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_RED_TIME:        red_time        <= cfg_data;
        REG_RED_YELLOW_TIME: red_yellow_time <= cfg_data;
        REG_GREEN_TIME:      green_time      <= cfg_data;
        REG_GREEN_MIN_TIME:  green_min_time  <= cfg_data;
        REG_YELLOW_TIME:     yellow_time     <= cfg_data;
        default: ;
      endcase
    end
  end

  // saturating time accumulation
  always_comb begin
    sum      = (CW+1)'(phase_time) + (CW+1)'(elapsed);
    sat_time = (sum > TIME_MAX) ? {TIME_WIDTH{1'b1}} : sum[TIME_WIDTH-1:0];
    cmp_time = CW'(sat_time);
  end

  // press only counts when the step starts in green
  assign pend_seen = walk_pending || (walk_button && (phase == PH_GREEN));

  // next state
  always_comb begin
    phase_next        = phase;
    phase_time_next   = sat_time;
    walk_pending_next = pend_seen;
    case (phase)
      PH_RED: begin
        if (cmp_time >= CW'(red_time)) begin
          phase_next      = PH_RED_YELLOW;
          phase_time_next = '0;
        end
      end
      PH_RED_YELLOW: begin
        if (cmp_time >= CW'(red_yellow_time)) begin
          phase_next      = PH_GREEN;
          phase_time_next = '0;
        end
      end
      PH_GREEN: begin
        // full length wins and leaves the request latched
        if (cmp_time >= CW'(green_time)) begin
          phase_next      = PH_YELLOW;
          phase_time_next = '0;
        end else if (pend_seen && (cmp_time >= CW'(green_min_time))) begin
          phase_next        = PH_YELLOW;
          phase_time_next   = '0;
          walk_pending_next = 1'b0;
        end
      end
      PH_YELLOW: begin
        if (cmp_time >= CW'(yellow_time)) begin
          phase_next      = PH_RED;
          phase_time_next = '0;
        end
      end
      default: begin
        phase_next      = PH_RED;
        phase_time_next = '0;
      end
    endcase
  end

  // lamp outputs of the phase after the update
  always_comb begin
    red_lamp    = 1'b0;
    yellow_lamp = 1'b0;
    green_lamp  = 1'b0;
    case (phase_next)
      PH_RED:        red_lamp = 1'b1;
      PH_RED_YELLOW: begin
        red_lamp    = 1'b1;
        yellow_lamp = 1'b1;
      end
      PH_GREEN:      green_lamp  = 1'b1;
      PH_YELLOW:     yellow_lamp = 1'b1;
      default: ;
    endcase
  end

  // state registers advance once per accepted beat
  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_RED;
      phase_time   <= '0;
      walk_pending <= 1'b0;
    end else if (s_accept) begin
      phase        <= phase_next;
      phase_time   <= phase_time_next;
      walk_pending <= walk_pending_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (s_accept) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_accept) begin
      m_tdata <= {2'b00, walk_pending_next, green_lamp, yellow_lamp, red_lamp,
                  phase_next};
    end
  end

endmodule

`default_nettype wire

// ----- design/tls_checker.sv -----
// port-level checks for the traffic light sequencer, bound to the top level
`default_nettype none

module tls_checker
  import tls_pkg::*;
(
  input wire logic                  clk,
  input wire logic                  rst,
  input wire logic                  s_tvalid,
  input wire logic                  s_tready,
  input wire logic                  m_tvalid,
  input wire logic                  m_tready,
  input wire logic [OUT_DATA_W-1:0] m_tdata
);

  logic out_red;
  logic out_yellow;
  logic out_green;
  logic [1:0] out_phase;

  assign out_phase  = m_tdata[1:0];
  assign out_red    = m_tdata[2];
  assign out_yellow = m_tdata[3];
  assign out_green  = m_tdata[4];

  // a held result beat stays put
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result beat changed while stalled");

  // no input beat is taken while a result beat is stuck
  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |-> !s_tready)
    else $error("input taken over a stalled result");

  // every accepted input beat yields a result beat next cycle
  a_one_result: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> m_tvalid)
    else $error("accepted beat produced no result");

  // lamps agree with the reported phase
  a_lamps: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (out_red == (out_phase == PH_RED || out_phase == PH_RED_YELLOW))
              && (out_yellow == (out_phase == PH_RED_YELLOW || out_phase == PH_YELLOW))
              && (out_green == (out_phase == PH_GREEN)))
    else $error("lamp levels do not match phase");

  // output buffer empty right after reset
  a_reset: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result valid after reset");

endmodule

bind traffic_light_sequencer_top tls_checker u_tls_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

`default_nettype wire
